[hw/rtl/matrix_multiply_engine_top_assert.svh]
// Assertion macros for the matrix multiply engine checker.
// No dependencies; included by the checker file.
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MME_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mme_pkg.sv]
// Matrix multiply engine package: sizes, codes, helper functions and the
// sequencer microcode table. No dependencies.
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int VALUE_BITS = 16;

  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int FUNC_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int PROD_W  = 2 * VALUE_BITS;
  localparam int SUM_W   = 2 * VALUE_BITS + $clog2(MAX_DIM);

  // Input item functions
  localparam logic [FUNC_W-1:0] FUNC_WR_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // Sequencer steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MAC    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DRAIN2 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RET    = 3'd5;

  // Branch conditions: taken goes to target; not taken goes to the next step unless noted
  typedef enum logic [1:0] {
    COND_JUMP,    // always taken
    COND_CMD,     // taken on a multiply transfer, else hold
    COND_T_MORE,  // taken while inner index is not the last
    COND_EMIT     // hold while output busy, taken unless last entry
  } cond_e;

  typedef struct packed {
    logic                in_rdy;
    logic                mac;
    logic                emit;
    cond_e               cond;
    logic [STEP_W-1:0]   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{in_rdy: 1'b1, mac: 1'b0, emit: 1'b0, cond: COND_CMD, target: STEP_MAC};
    unique case (step)
      STEP_IDLE:   w = '{in_rdy: 1'b1, mac: 1'b0, emit: 1'b0, cond: COND_CMD,
                         target: STEP_MAC};
      STEP_MAC:    w = '{in_rdy: 1'b0, mac: 1'b1, emit: 1'b0, cond: COND_T_MORE,
                         target: STEP_MAC};
      STEP_DRAIN1: w = '{in_rdy: 1'b0, mac: 1'b0, emit: 1'b0, cond: COND_JUMP,
                         target: STEP_DRAIN2};
      STEP_DRAIN2: w = '{in_rdy: 1'b0, mac: 1'b0, emit: 1'b0, cond: COND_JUMP,
                         target: STEP_EMIT};
      STEP_EMIT:   w = '{in_rdy: 1'b0, mac: 1'b0, emit: 1'b1, cond: COND_EMIT,
                         target: STEP_MAC};
      STEP_RET:    w = '{in_rdy: 1'b0, mac: 1'b0, emit: 1'b0, cond: COND_JUMP,
                         target: STEP_IDLE};
      default:     w = '{in_rdy: 1'b0, mac: 1'b0, emit: 1'b0, cond: COND_JUMP,
                         target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Last valid index for a size register: zero acts as one, large values saturate
  function automatic logic [IDX_W-1:0] dim_last(logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - DIM_W'(1));
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [IDX_W-1:0] row,
                                                  logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mme_if.sv]
// Channel interfaces of the matrix multiply engine: input items, results
// and configuration writes. Depends on mme_pkg.
`default_nettype none

interface mme_in_if import mme_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [FUNC_W-1:0]            func;
  logic [IDX_W-1:0]             elem_row;
  logic [IDX_W-1:0]             elem_col;
  logic signed [VALUE_BITS-1:0] elem_value;

  modport source (output valid, func, elem_row, elem_col, elem_value, input ready);
  modport sink   (input valid, func, elem_row, elem_col, elem_value, output ready);
endinterface

interface mme_out_if import mme_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [SUM_W-1:0] product_sum;
  logic                    last_entry;

  modport source (output valid, out_row, out_col, product_sum, last_entry, input ready);
  modport sink   (input valid, out_row, out_col, product_sum, last_entry, output ready);
endinterface

interface mme_cfg_if import mme_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/matrix_multiply_engine_top.sv]
// Multiply item: the next item is taken only after the last result of the run has been
// emitted, and the results leave one at a time as each dot product is drained. Write
// items are taken while idle. The pace is set by the single multiply-accumulate unit
// and the one read port of each element store.
// Reset (rst_ni low, asynchronous) sets all sizes to 8, returns the sequencer to idle
// and drops the output valid; the element stores keep no reset value.
`default_nettype none

module matrix_multiply_engine_top import mme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mme_in_if.sink    in_i,
  mme_out_if.source out_o,
  mme_cfg_if.sink   cfg_i
);

  logic [DIM_W-1:0] rows_m_q, inner_k_q, cols_n_q;
  logic [IDX_W-1:0] m_last, k_last, n_last;

  logic [STEP_W-1:0] upc_q, upc_d;
  ucode_t            uw;

  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, t_q, t_d;

  logic signed [VALUE_BITS-1:0] left_mem  [DEPTH];
  logic signed [VALUE_BITS-1:0] right_mem [DEPTH];
  logic signed [VALUE_BITS-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [SUM_W-1:0]      acc_q;
  logic                         v1_q, v2_q;

  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic                    out_last_q;

  logic in_acc, mul_acc, wr_a, wr_b, out_free, is_last, emit_go, acc_clr;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= DIM_RESET;
      inner_k_q <= DIM_RESET;
      cols_n_q  <= DIM_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ROWS_M:  rows_m_q  <= cfg_i.data;
        CFG_INNER_K: inner_k_q <= cfg_i.data;
        CFG_COLS_N:  cols_n_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign m_last = dim_last(rows_m_q);
  assign k_last = dim_last(inner_k_q);
  assign n_last = dim_last(cols_n_q);

  // Sequencer
  assign uw         = ucode_rom(upc_q);
  assign in_i.ready = uw.in_rdy;
  assign in_acc     = in_i.valid && uw.in_rdy;
  assign mul_acc    = in_acc && (in_i.func == FUNC_MUL);
  assign wr_a = in_acc && (in_i.func == FUNC_WR_A)
             && (in_i.elem_row <= m_last) && (in_i.elem_col <= k_last);
  assign wr_b = in_acc && (in_i.func == FUNC_WR_B)
             && (in_i.elem_row <= k_last) && (in_i.elem_col <= n_last);

  assign out_free = !out_valid_q || out_o.ready;
  assign is_last  = (i_q == m_last) && (j_q == n_last);
  assign emit_go  = uw.emit && out_free;
  assign acc_clr  = mul_acc || emit_go;

  always_comb begin
    upc_d = upc_q;
    unique case (uw.cond)
      COND_JUMP:   upc_d = uw.target;
      COND_CMD:    if (mul_acc) upc_d = uw.target;
      COND_T_MORE: upc_d = (t_q != k_last) ? uw.target : upc_q + STEP_W'(1);
      COND_EMIT: begin
        if (out_free) upc_d = is_last ? upc_q + STEP_W'(1) : uw.target;
      end
      default:     upc_d = STEP_IDLE;
    endcase
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    t_d = t_q;
    if (mul_acc) begin
      i_d = '0;
      j_d = '0;
      t_d = '0;
    end else begin
      if (uw.mac) t_d = (t_q == k_last) ? '0 : t_q + IDX_W'(1);
      if (emit_go) begin
        if (j_q == n_last) begin
          j_d = '0;
          i_d = i_q + IDX_W'(1);
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
      i_q   <= '0;
      j_q   <= '0;
      t_q   <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      upc_q <= upc_d;
      i_q   <= i_d;
      j_q   <= j_d;
      t_q   <= t_d;
      v1_q  <= uw.mac;
      v2_q  <= v1_q;
    end
  end

  // Element stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_a) left_mem[store_addr(in_i.elem_row, in_i.elem_col)] <= in_i.elem_value;
    if (uw.mac) a_rd_q <= left_mem[store_addr(i_q, t_q)];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) right_mem[store_addr(in_i.elem_row, in_i.elem_col)] <= in_i.elem_value;
    if (uw.mac) b_rd_q <= right_mem[store_addr(t_q, j_q)];
  end

  // Multiply-accumulate
  always_ff @(posedge clk_i) begin
    if (v1_q) prod_q <= a_rd_q * b_rd_q;
    if (acc_clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_row_q  <= i_q;
      out_col_q  <= j_q;
      out_sum_q  <= acc_q;
      out_last_q <= is_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_row     = out_row_q;
  assign out_o.out_col     = out_col_q;
  assign out_o.product_sum = out_sum_q;
  assign out_o.last_entry  = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/mme_checker.sv]
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix_multiply_engine_top_assert.svh.
`default_nettype none

`include "matrix_multiply_engine_top_assert.svh"

module mme_checker import mme_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic [FUNC_W-1:0]       in_func_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [SUM_W-1:0] out_sum_i,
  input logic                    out_last_i
);

  `MME_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_sum_i), "stalled result changed")
  `MME_ASSERT_NXT(a_mul_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_func_i == FUNC_MUL), !in_ready_i, "input taken during multiply run")
  `MME_ASSERT_IMP(a_run_open, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "input ready before run ended")
  `MME_ASSERT_IMP(a_emit_busy, clk_i, rst_ni, $rose(out_valid_i), !in_ready_i, "result appeared while idle")

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_sum_i   (out_o.product_sum),
  .out_last_i  (out_o.last_entry)
);

`default_nettype wire
